// ----- design/ring_deque_indexed_insert_erase_assert.svh -----
// Assertion helpers for the deque design file.
`ifndef RING_DEQUE_INDEXED_INSERT_ERASE_ASSERT_SVH
`define RING_DEQUE_INDEXED_INSERT_ERASE_ASSERT_SVH
`ifndef SYNTHESIS
// check on every edge out of reset
`define RDIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// check on every edge, reset included
`define RDIE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDIE_ASSERT(lbl, prop, msg)
`define RDIE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- design/rdie_pkg.sv -----
package rdie_pkg;

  localparam int AW    = 10;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = AW + 1;
  localparam int DW    = 32;
  localparam int IN_W  = 48;
  localparam int OUT_W = 48;

  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_DRAIN,
    S_RDWAIT,
    S_DONE
  } state_t;

  // one pending element move: destination slot of the word in flight
  typedef struct packed {
    logic          vld;
    logic [AW-1:0] addr;
  } move_t;

endpackage

// ----- design/rdie_ram.sv -----
module rdie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/rdie_cell.sv -----
module rdie_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  rdie_pkg::move_t tag_i,
  output rdie_pkg::move_t tag_o
);

  logic                    vld_r;
  logic [rdie_pkg::AW-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tag_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= tag_i.addr;
  end

  assign tag_o.vld  = vld_r;
  assign tag_o.addr = addr_r;

endmodule

// ----- design/ring_deque_indexed_insert_erase.sv -----
// An insert or erase moves n elements, n below DEPTH/2, one per cycle through the
// single-write store and a two-cell move chain.
// One item is in work at a time; the next is taken the cycle after its result is queued.
// Reset clears head offset, count and control; store contents stay undefined.
module ring_deque_indexed_insert_erase (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // op[1:0], index[11:2], write_data[43:12], zero fill above
  input  logic [rdie_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // read_data[31:0], count[42:32], status[44:43], zero fill above
  output logic [rdie_pkg::OUT_W-1:0] out_tdata
);

  `include "ring_deque_indexed_insert_erase_assert.svh"

  localparam int AW = rdie_pkg::AW;
  localparam int CW = rdie_pkg::CW;
  localparam int DW = rdie_pkg::DW;

  rdie_pkg::state_t state_r, state_nxt;

  logic [1:0]    op_r, op_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [DW-1:0] wdata_r, wdata_nxt;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [AW-1:0] dst_r, dst_nxt;
  logic          up_r, up_nxt;
  logic [AW-1:0] rem_r, rem_nxt;
  logic          put_en_r, put_en_nxt;
  logic [AW-1:0] put_addr_r, put_addr_nxt;

  logic [1:0]    status_r, status_nxt;
  logic [DW-1:0] rdata_r, rdata_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_rdata_r, out_rdata_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  rdie_pkg::move_t issue_tag, c0_tag, c1_tag;

  logic          accept;
  logic          issue;
  logic          drained;
  logic          put_fire;
  logic          load_out;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [DW-1:0] ram_wr_data;
  logic [AW-1:0] ram_rd_addr;
  logic [DW-1:0] ram_rd_data;

  logic [CW-1:0] idx_w;
  logic [CW-1:0] right_span;
  logic          rd_ok;
  logic          ins_range;
  logic          is_full;
  logic          ins_left;
  logic          er_range;
  logic          er_left;

  // ---- decode of the held item
  assign idx_w      = {1'b0, idx_r};
  assign right_span = count_r - idx_w;
  assign rd_ok      = idx_w < count_r;
  assign ins_range  = idx_w > count_r;
  assign is_full    = count_r == rdie_pkg::FULL_COUNT;
  assign ins_left   = idx_w < right_span;
  assign er_range   = idx_w >= count_r;
  assign er_left    = idx_w < (right_span - CW'(1));

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rdie_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = rdie_pkg::S_EXEC;
        end
      end
      rdie_pkg::S_EXEC: begin
        case (op_r)
          rdie_pkg::OP_READ:   state_nxt = rd_ok ? rdie_pkg::S_RDWAIT : rdie_pkg::S_DONE;
          rdie_pkg::OP_INSERT: state_nxt = (ins_range || is_full) ? rdie_pkg::S_DONE
                                                                  : rdie_pkg::S_MOVE;
          rdie_pkg::OP_ERASE:  state_nxt = er_range ? rdie_pkg::S_DONE : rdie_pkg::S_MOVE;
          default:             state_nxt = rdie_pkg::S_DONE;
        endcase
      end
      rdie_pkg::S_MOVE: begin
        if (rem_r == '0) begin
          state_nxt = rdie_pkg::S_DRAIN;
        end
      end
      rdie_pkg::S_DRAIN: begin
        if (drained) begin
          state_nxt = rdie_pkg::S_DONE;
        end
      end
      rdie_pkg::S_RDWAIT: state_nxt = rdie_pkg::S_DONE;
      rdie_pkg::S_DONE: begin
        if (load_out) begin
          state_nxt = rdie_pkg::S_IDLE;
        end
      end
      default: state_nxt = rdie_pkg::S_IDLE;
    endcase
  end

  // ---- control outputs
  always_comb begin
    in_tready = state_r == rdie_pkg::S_IDLE;
    accept    = in_tvalid && in_tready;
    issue     = (state_r == rdie_pkg::S_MOVE) && (rem_r != '0);
    drained   = !c0_tag.vld && !c1_tag.vld;
    put_fire  = (state_r == rdie_pkg::S_DRAIN) && drained && put_en_r;
    load_out  = (state_r == rdie_pkg::S_DONE) && (!out_valid_r || out_tready);

    issue_tag.vld  = issue;
    issue_tag.addr = dst_r;

    // source slot sits one step beyond the destination, in the move direction
    if (state_r == rdie_pkg::S_EXEC) begin
      ram_rd_addr = head_r + idx_r;
    end else if (up_r) begin
      ram_rd_addr = c0_tag.addr + AW'(1);
    end else begin
      ram_rd_addr = c0_tag.addr - AW'(1);
    end

    ram_wr_en   = c1_tag.vld || put_fire;
    ram_wr_addr = c1_tag.vld ? c1_tag.addr : put_addr_r;
    ram_wr_data = c1_tag.vld ? ram_rd_data : wdata_r;
  end

  // ---- datapath next values
  always_comb begin
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    wdata_nxt      = wdata_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    dst_nxt        = dst_r;
    up_nxt         = up_r;
    rem_nxt        = rem_r;
    put_en_nxt     = put_en_r;
    put_addr_nxt   = put_addr_r;
    status_nxt     = status_r;
    rdata_nxt      = rdata_r;
    out_rdata_nxt  = out_rdata_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    if (accept) begin
      op_nxt    = in_tdata[1:0];
      idx_nxt   = in_tdata[11:2];
      wdata_nxt = in_tdata[43:12];
    end

    if (state_r == rdie_pkg::S_EXEC) begin
      status_nxt = rdie_pkg::ST_OK;
      rdata_nxt  = '0;
      put_en_nxt = 1'b0;
      case (op_r)
        rdie_pkg::OP_READ: begin
          if (!rd_ok) begin
            status_nxt = rdie_pkg::ST_RANGE;
          end
        end
        rdie_pkg::OP_INSERT: begin
          if (ins_range) begin
            status_nxt = rdie_pkg::ST_RANGE;
          end else if (is_full) begin
            status_nxt = rdie_pkg::ST_FULL;
          end else begin
            count_nxt  = count_r + CW'(1);
            put_en_nxt = 1'b1;
            if (ins_left) begin
              // head steps back; front elements slide toward it
              head_nxt     = head_r - AW'(1);
              dst_nxt      = head_r - AW'(1);
              up_nxt       = 1'b1;
              rem_nxt      = idx_r;
              put_addr_nxt = head_r - AW'(1) + idx_r;
            end else begin
              dst_nxt      = head_r + count_r[AW-1:0];
              up_nxt       = 1'b0;
              rem_nxt      = right_span[AW-1:0];
              put_addr_nxt = head_r + idx_r;
            end
          end
        end
        rdie_pkg::OP_ERASE: begin
          if (er_range) begin
            status_nxt = rdie_pkg::ST_RANGE;
          end else begin
            count_nxt = count_r - CW'(1);
            dst_nxt   = head_r + idx_r;
            if (er_left) begin
              head_nxt = head_r + AW'(1);
              up_nxt   = 1'b0;
              rem_nxt  = idx_r;
            end else begin
              up_nxt  = 1'b1;
              rem_nxt = right_span[AW-1:0] - AW'(1);
              if (count_r == CW'(1)) begin
                head_nxt = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (issue) begin
      dst_nxt = up_r ? dst_r + AW'(1) : dst_r - AW'(1);
      rem_nxt = rem_r - AW'(1);
    end

    if (state_r == rdie_pkg::S_RDWAIT) begin
      rdata_nxt = ram_rd_data;
    end

    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_rdata_nxt  = rdata_r;
      out_count_nxt  = count_r;
      out_status_nxt = status_r;
    end
  end

  // ---- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdie_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    wdata_r      <= wdata_nxt;
    dst_r        <= dst_nxt;
    up_r         <= up_nxt;
    rem_r        <= rem_nxt;
    put_en_r     <= put_en_nxt;
    put_addr_r   <= put_addr_nxt;
    status_r     <= status_nxt;
    rdata_r      <= rdata_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  // ---- move chain: cell 0 holds the read, cell 1 the write of each word
  rdie_cell u_cell0 (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (issue_tag),
    .tag_o (c0_tag)
  );

  rdie_cell u_cell1 (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (c0_tag),
    .tag_o (c1_tag)
  );

  rdie_ram #(
    .WIDTH (DW),
    .DEPTH (rdie_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_status_r, out_count_r, out_rdata_r};

  // ---- checks
  `RDIE_ASSERT(a_count_bound, count_r <= rdie_pkg::FULL_COUNT, "count above store depth")
  `RDIE_ASSERT(a_empty_head, (count_r == '0) |-> (head_r == '0), "empty deque with nonzero head")
  `RDIE_ASSERT(a_move_window, c1_tag.vld |-> (state_r == rdie_pkg::S_MOVE || state_r == rdie_pkg::S_DRAIN), "word move outside shift phase")
  `RDIE_ASSERT(a_rem_step, issue |=> (rem_r == $past(rem_r) - AW'(1)), "move counter skipped")
  `RDIE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == rdie_pkg::S_IDLE && !out_valid_r), "not idle after reset")

endmodule

// ----- tb/ring_deque_indexed_insert_erase_tb.sv -----
`timescale 1ns / 1ps

module ring_deque_indexed_insert_erase_tb;

  localparam int AW    = rdie_pkg::AW;
  localparam int CW    = rdie_pkg::CW;
  localparam int DW    = rdie_pkg::DW;
  localparam int DEPTH = rdie_pkg::DEPTH;
  localparam int IN_W  = rdie_pkg::IN_W;
  localparam int OUT_W = rdie_pkg::OUT_W;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [1:0]    op;
    logic [AW-1:0] index;
    logic [DW-1:0] data;
    bit            drain_first;
  } deque_op_t;

  typedef struct {
    logic [DW-1:0]     read_data;
    logic [CW-1:0]     count;
    rdie_pkg::status_t status;
  } deque_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // predictor state
  bit   [DW-1:0] ring_mem [DEPTH];
  logic [AW-1:0] ring_head = '0;
  logic [CW-1:0] ring_count = '0;

  deque_op_t     op_q[$];
  deque_result_t deque_results_q[$];
  deque_op_t     cur_op;
  int            gen_count = 0;
  int            burst_left = 0;
  int            gap_left = 0;
  logic [15:0]   stall_pat = '0;
  int            pat_age = 0;
  int            idle_cycles = 0;
  int            mismatches = 0;
  int            words_out = 0;

  ring_deque_indexed_insert_erase dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [AW-1:0] ring_slot(int unsigned pos);
    return ring_head + pos[AW-1:0];
  endfunction

  function automatic deque_result_t deque_apply(deque_op_t w);
    deque_result_t r;
    int unsigned   n;
    int unsigned   k;
    int unsigned   i;
    n = ring_count;
    k = w.index;
    r.read_data = '0;
    r.status = rdie_pkg::ST_OK;
    case (w.op)
      rdie_pkg::OP_READ: begin
        if (k < n) r.read_data = ring_mem[ring_slot(k)];
        else r.status = rdie_pkg::ST_RANGE;
      end
      rdie_pkg::OP_INSERT: begin
        if (k > n) begin
          r.status = rdie_pkg::ST_RANGE;
        end else if (n == DEPTH) begin
          r.status = rdie_pkg::ST_FULL;
        end else begin
          if (k < n - k) begin
            // open the hole on the front side: head steps back
            ring_head = ring_head - 1'b1;
            for (i = 0; i < k; i++) ring_mem[ring_slot(i)] = ring_mem[ring_slot(i + 1)];
          end else begin
            for (i = n; i > k; i--) ring_mem[ring_slot(i)] = ring_mem[ring_slot(i - 1)];
          end
          ring_mem[ring_slot(k)] = w.data;
          ring_count = ring_count + 1'b1;
        end
      end
      rdie_pkg::OP_ERASE: begin
        if (k >= n) begin
          r.status = rdie_pkg::ST_RANGE;
        end else begin
          if (k < n - 1 - k) begin
            for (i = k; i > 0; i--) ring_mem[ring_slot(i)] = ring_mem[ring_slot(i - 1)];
            ring_head = ring_head + 1'b1;
          end else begin
            for (i = k; i + 1 < n; i++) ring_mem[ring_slot(i)] = ring_mem[ring_slot(i + 1)];
          end
          ring_count = ring_count - 1'b1;
          if (ring_count == 0) ring_head = '0;
        end
      end
      default: ;
    endcase
    r.count = ring_count;
    return r;
  endfunction

  task automatic queue_op(logic [1:0] op, int idx, logic [DW-1:0] data,
                          bit drain_first = 1'b0);
    deque_op_t w;
    w.op = op;
    w.index = idx[AW-1:0];
    w.data = data;
    w.drain_first = drain_first;
    op_q.push_back(w);
    // track the fill level so indexes can be aimed while generating
    if (op == rdie_pkg::OP_INSERT && idx <= gen_count && gen_count < DEPTH) gen_count++;
    else if (op == rdie_pkg::OP_ERASE && idx < gen_count) gen_count--;
  endtask

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: word %0d %s mismatch: expected 0x%0h, got 0x%0h",
               $time, words_out, what, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) deque_results_q.push_back(deque_apply(cur_op));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (op_q.size() != 0 &&
                     !(op_q[0].drain_first && deque_results_q.size() != 0)) begin
          cur_op = op_q.pop_front();
          in_tdata <= {4'b0, cur_op.data, cur_op.index, cur_op.op};
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25)
                                                   : $urandom_range(0, 2);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pat = '0;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom & $urandom);
          default: stall_pat = 16'($urandom | $urandom);
        endcase
      end
      pat_age--;
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      out_tready <= !stall_pat[0];
    end
  end

  // monitor
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (deque_results_q.size() == 0) begin
        report_mismatch("unexpected word", 0, out_tdata);
      end else begin
        want = deque_results_q.pop_front();
        if (out_tdata[31:0] !== want.read_data)
          report_mismatch("read_data", want.read_data, out_tdata[31:0]);
        if (out_tdata[42:32] !== want.count)
          report_mismatch("count", want.count, out_tdata[42:32]);
        if (out_tdata[44:43] !== want.status)
          report_mismatch("status", want.status, out_tdata[44:43]);
      end
    end
  end

  // watchdog: no word moved on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         n;
    int         r;
    int         s;
    int         idx;
    int         lim;
    logic [1:0] op;

    // empty deque, range checks, unused code
    queue_op(rdie_pkg::OP_READ, 0, '0);
    queue_op(rdie_pkg::OP_ERASE, 0, '0);
    queue_op(rdie_pkg::OP_INSERT, 1, 32'h1111_1111);
    queue_op(OP_UNUSED, 0, 32'hFFFF_FFFF);
    // build up with both sides moving, head wraps below zero
    queue_op(rdie_pkg::OP_INSERT, 0, 32'h0000_0000);
    queue_op(rdie_pkg::OP_INSERT, 1, 32'hFFFF_FFFF);
    queue_op(rdie_pkg::OP_INSERT, 0, 32'hA5A5_A5A5);
    queue_op(rdie_pkg::OP_INSERT, 3, 32'h5A5A_5A5A);
    queue_op(rdie_pkg::OP_INSERT, 2, 32'h0F0F_F0F0);
    queue_op(rdie_pkg::OP_INSERT, 1, 32'h1234_5678);
    queue_op(rdie_pkg::OP_INSERT, 7, 32'hDEAD_0001);
    queue_op(rdie_pkg::OP_READ, 0, '0);
    queue_op(rdie_pkg::OP_READ, 5, '0);
    queue_op(rdie_pkg::OP_READ, 6, '0);
    queue_op(rdie_pkg::OP_READ, 1023, '0);
    queue_op(OP_UNUSED, 1023, $urandom);
    queue_op(rdie_pkg::OP_ERASE, 1, '0);
    queue_op(rdie_pkg::OP_ERASE, 4, '0);
    queue_op(rdie_pkg::OP_ERASE, 1, '0);
    queue_op(rdie_pkg::OP_ERASE, 1023, '0);
    queue_op(rdie_pkg::OP_INSERT, 1023, $urandom);
    queue_op(rdie_pkg::OP_READ, 1, '0);
    // empty out: head must return to zero
    queue_op(rdie_pkg::OP_ERASE, 0, '0);
    queue_op(rdie_pkg::OP_ERASE, 0, '0);
    queue_op(rdie_pkg::OP_ERASE, 0, '0);
    queue_op(rdie_pkg::OP_INSERT, 0, $urandom, 1'b1);
    queue_op(rdie_pkg::OP_READ, 0, '0);

    // mixed traffic at low fill
    for (n = 0; n < 50; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_UNUSED;
      else if (r < 30) op = rdie_pkg::OP_READ;
      else if (r < 65 + (gen_count < 6 ? 20 : 0) - (gen_count > 40 ? 30 : 0))
        op = rdie_pkg::OP_INSERT;
      else op = rdie_pkg::OP_ERASE;
      lim = (op == rdie_pkg::OP_INSERT) ? gen_count : gen_count - 1;
      if (lim < 0 || $urandom_range(0, 9) == 0) idx = $urandom_range(0, 1023);
      else idx = $urandom_range(0, lim);
      queue_op(op, idx, $urandom, $urandom_range(0, 99) == 0);
    end

    // fill to the top, mostly near the ends to keep moves short
    while (gen_count < DEPTH) begin
      r = $urandom_range(0, 99);
      lim = (gen_count < 4) ? gen_count : 4;
      if (r < 94) begin
        s = $urandom_range(0, 9);
        if (s < 4) idx = 0;
        else if (s < 8) idx = gen_count;
        else if (s == 8) idx = $urandom_range(0, lim);
        else idx = gen_count - $urandom_range(0, lim);
        queue_op(rdie_pkg::OP_INSERT, idx, $urandom);
      end else if (r < 97 && gen_count > 0) begin
        queue_op(rdie_pkg::OP_READ, $urandom_range(0, gen_count - 1), '0);
      end else if (r < 98 && gen_count > 0) begin
        queue_op(rdie_pkg::OP_ERASE, $urandom_range(0, 1) ? 0 : gen_count - 1, $urandom);
      end else if (r < 99 || gen_count >= 1023) begin
        queue_op(OP_UNUSED, $urandom_range(0, 1023), $urandom);
      end else begin
        queue_op(rdie_pkg::OP_INSERT, $urandom_range(gen_count + 1, 1023), $urandom);
      end
    end

    // full store
    queue_op(rdie_pkg::OP_INSERT, 0, $urandom, 1'b1);
    queue_op(rdie_pkg::OP_INSERT, 1023, $urandom);
    queue_op(rdie_pkg::OP_INSERT, 512, $urandom);
    queue_op(rdie_pkg::OP_READ, 1023, '0);
    queue_op(rdie_pkg::OP_READ, 0, '0);
    queue_op(rdie_pkg::OP_ERASE, 511, '0);
    queue_op(rdie_pkg::OP_INSERT, 511, 32'hFFFF_FFFF);
    queue_op(rdie_pkg::OP_ERASE, 1023, '0);
    queue_op(rdie_pkg::OP_INSERT, 1023, 32'h0000_0000);
    queue_op(rdie_pkg::OP_ERASE, 0, '0);
    queue_op(rdie_pkg::OP_INSERT, 0, $urandom);
    for (n = 0; n < 40; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        queue_op(rdie_pkg::OP_READ, $urandom_range(0, 1023), '0);
      end else if (r < 65 || gen_count == 0) begin
        queue_op(rdie_pkg::OP_INSERT, $urandom_range(0, gen_count > 1023 ? 1023 : gen_count),
                 $urandom);
      end else begin
        queue_op(rdie_pkg::OP_ERASE, $urandom_range(0, gen_count - 1), '0);
      end
    end
    queue_op(rdie_pkg::OP_READ, $urandom_range(0, 1023), '0, 1'b1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (op_q.size() != 0 || in_tvalid || deque_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
